>>> src/rpib_pkg.sv
// Package for the radix prefix index builder.
// Holds the result kind codes and the result slot layout. No dependencies.
package rpib_pkg;

  // Result kind codes: compact entry, then index nodes of levels 0..3.
  localparam logic [2:0] KIND_ENTRY = 3'd0;
  localparam logic [2:0] KIND_NODE0 = 3'd1;

  // Number of prefix levels of the index.
  localparam int unsigned NUM_LEVELS = 4;

  // Result slots of one request, in emission order:
  // seed nodes, closed nodes, compact entry, flushed nodes.
  localparam int unsigned NUM_SLOTS = 13;
  localparam logic [3:0] SLOT_SEED0  = 4'd0;
  localparam logic [3:0] SLOT_CLOSE0 = 4'd4;
  localparam logic [3:0] SLOT_ENTRY  = 4'd8;
  localparam logic [3:0] SLOT_FLUSH0 = 4'd9;

  typedef logic [NUM_SLOTS-1:0] slot_mask_t;
  typedef logic [3:0] slot_t;
  typedef logic [1:0] level_t;

endpackage

>>> src/radix_prefix_index_builder.sv
// Top level of the radix prefix index builder.
// Depends on rpib_pkg for kind codes and the result slot layout.
//
// Usage: sorted keys arrive one request at a time on the in_ channel, each
// with a 64-bit payload and a final_row flag. Each request yields one to
// nine results on the out_ channel: seed nodes on the first row of a table,
// index nodes closed by a prefix byte change, one compact entry, and four
// flushed nodes on the final row. out_run_end marks the last result of a
// request. Index state is updated in the cycle a request is accepted.
// The first result of a request goes from the holding stage to the output
// register. Throughput: one result per cycle while out_stall is low; this
// is set by the single output register.
// A request holding stage sits in front of the output register, so a new
// request is taken while a finished result waits on out_stall.
// Reset (rst_n low, synchronous) clears both stages and all index state.
// While out_stall is high the output holds and, once the holding stage is
// full, in_stall rises.
module radix_prefix_index_builder #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_key,
  input  logic [63:0] in_payload,
  input  logic        in_final_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_node_byte,
  output logic [31:0] out_node_link,
  output logic [31:0] out_entry_low,
  output logic [63:0] out_entry_value,
  output logic        out_run_end
);
  import rpib_pkg::*;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  localparam cnt_t CNT_MAX = {COUNT_WIDTH{1'b1}};

  // Saturating increment of a counter.
  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == CNT_MAX) ? v : v + cnt_t'(1);
  endfunction

  // Index state.
  logic [31:0] prev_bytes_r;
  cnt_t        level1_size_r, level2_size_r, level3_size_r, row_count_r;
  logic        started_r;

  // Request holding stage.
  logic        a_valid_r;
  slot_mask_t  a_mask_r;
  logic [31:0] a_key_low_r;
  logic [63:0] a_payload_r;
  logic [31:0] a_kb_r, a_prev_r;
  logic [31:0] a_base1_r, a_base2_r, a_base3_r, a_prior_r;
  logic [31:0] a_post1_r, a_post2_r, a_post3_r, a_row_r;

  // Output register.
  logic        out_valid_r;
  logic [2:0]  out_kind_r;
  logic [7:0]  out_node_byte_r;
  logic [31:0] out_node_link_r, out_entry_low_r;
  logic [63:0] out_entry_value_r;
  logic        out_run_end_r;

  // Handshake.
  logic r_free, a_last, a_move, accept;
  slot_mask_t a_rest;

  assign a_rest   = a_mask_r & (a_mask_r - slot_mask_t'(1));
  assign a_last   = (a_rest == '0);
  assign r_free   = !out_valid_r || !out_stall;
  assign a_move   = a_valid_r && r_free;
  assign in_stall = a_valid_r && !(a_last && r_free);
  assign accept   = in_valid && !in_stall;

  // Per-request evaluation of the index state.
  logic [31:0] kb, prev_base;
  logic [3:0]  close;
  cnt_t        base1, base2, base3, row, prior_row, post1, post2, post3;
  slot_mask_t  mask_nxt;

  always_comb begin
    kb        = in_key[63:32];
    prev_base = started_r ? prev_bytes_r : kb;
    base1     = started_r ? level1_size_r : cnt_t'(1);
    base2     = started_r ? level2_size_r : cnt_t'(1);
    base3     = started_r ? level3_size_r : cnt_t'(1);
    row       = started_r ? row_count_r : '0;
    prior_row = (row == '0) ? '0 : row - cnt_t'(1);
    // A level closes when its byte or any higher byte changed.
    for (int k = 0; k < NUM_LEVELS; k++) begin
      close[k] = (kb[31-8*k -: 8] != prev_base[31-8*k -: 8]);
      if (k > 0) close[k] = close[k] | close[k-1];
    end
    post1 = close[1] ? sat_inc(base1) : base1;
    post2 = close[2] ? sat_inc(base2) : base2;
    post3 = close[3] ? sat_inc(base3) : base3;
    mask_nxt = '0;
    mask_nxt[SLOT_SEED0  +: NUM_LEVELS] = {NUM_LEVELS{!started_r}};
    mask_nxt[SLOT_CLOSE0 +: NUM_LEVELS] = close;
    mask_nxt[SLOT_ENTRY]                = 1'b1;
    mask_nxt[SLOT_FLUSH0 +: NUM_LEVELS] = {NUM_LEVELS{in_final_row}};
  end

  // Index state update; a final row returns everything to reset.
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_final_row)) begin
      prev_bytes_r  <= '0;
      level1_size_r <= '0;
      level2_size_r <= '0;
      level3_size_r <= '0;
      row_count_r   <= '0;
      started_r     <= 1'b0;
    end else if (accept) begin
      prev_bytes_r  <= kb;
      level1_size_r <= post1;
      level2_size_r <= post2;
      level3_size_r <= post3;
      row_count_r   <= sat_inc(row);
      started_r     <= 1'b1;
    end
  end

  // Holding stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (accept) begin
      a_valid_r <= 1'b1;
    end else if (a_move && a_last) begin
      a_valid_r <= 1'b0;
    end
  end

  // Holding stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_mask_r    <= mask_nxt;
      a_key_low_r <= in_key[31:0];
      a_payload_r <= in_payload;
      a_kb_r      <= kb;
      a_prev_r    <= prev_base;
      a_base1_r   <= 32'(base1);
      a_base2_r   <= 32'(base2);
      a_base3_r   <= 32'(base3);
      a_prior_r   <= 32'(prior_row);
      a_post1_r   <= 32'(post1);
      a_post2_r   <= 32'(post2);
      a_post3_r   <= 32'(post3);
      a_row_r     <= 32'(row);
    end else if (a_move) begin
      a_mask_r <= a_rest;
    end
  end

  // Decode the lowest pending slot into one result.
  slot_t       sel;
  level_t      lvl;
  logic [2:0]  kind_nxt;
  logic [7:0]  byte_nxt;
  logic [31:0] link_nxt, low_nxt;
  logic [63:0] value_nxt;

  always_comb begin
    sel = SLOT_ENTRY;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (a_mask_r[i]) sel = slot_t'(i);
    end
    kind_nxt  = KIND_ENTRY;
    byte_nxt  = '0;
    link_nxt  = '0;
    low_nxt   = '0;
    value_nxt = '0;
    lvl       = '0;
    if (sel < SLOT_CLOSE0) begin
      // Seed node: all fields zero but the kind.
      lvl      = level_t'(sel - SLOT_SEED0);
      kind_nxt = KIND_NODE0 + 3'(lvl);
    end else if (sel < SLOT_ENTRY) begin
      // Closed node: previous byte and pre-request sizes.
      lvl      = level_t'(sel - SLOT_CLOSE0);
      kind_nxt = KIND_NODE0 + 3'(lvl);
      byte_nxt = a_prev_r[31 - 8*lvl -: 8];
      case (lvl)
        2'd0:    link_nxt = a_base1_r;
        2'd1:    link_nxt = a_base2_r;
        2'd2:    link_nxt = a_base3_r;
        default: link_nxt = a_prior_r;
      endcase
    end else if (sel == SLOT_ENTRY) begin
      low_nxt   = a_key_low_r;
      value_nxt = a_payload_r;
    end else begin
      // Flushed node: current byte and sizes after the closes.
      lvl      = level_t'(sel - SLOT_FLUSH0);
      kind_nxt = KIND_NODE0 + 3'(lvl);
      byte_nxt = a_kb_r[31 - 8*lvl -: 8];
      case (lvl)
        2'd0:    link_nxt = a_post1_r;
        2'd1:    link_nxt = a_post2_r;
        2'd2:    link_nxt = a_post3_r;
        default: link_nxt = a_row_r;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (r_free) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      out_kind_r        <= kind_nxt;
      out_node_byte_r   <= byte_nxt;
      out_node_link_r   <= link_nxt;
      out_entry_low_r   <= low_nxt;
      out_entry_value_r <= value_nxt;
      out_run_end_r     <= a_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_node_byte   = out_node_byte_r;
  assign out_node_link   = out_node_link_r;
  assign out_entry_low   = out_entry_low_r;
  assign out_entry_value = out_entry_value_r;
  assign out_run_end     = out_run_end_r;

endmodule

>>> verif/tb_radix_prefix_index_builder.sv
`timescale 1ns / 100ps
// Self-checking testbench for radix_prefix_index_builder: directed and random key tables.
// Depends on rpib_pkg and the block; every result is predicted here and checked in order.
module tb_radix_prefix_index_builder;
  import rpib_pkg::*;

  localparam int unsigned COUNT_W      = 32;
  localparam logic [63:0] COUNT_CAP    = (64'd1 << COUNT_W) - 64'd1;
  localparam int unsigned HOLD_CYCLES  = 90;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned TAIL_CYCLES  = 16;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DEFAULT_IDLE = 21;

  // One result as it appears on the out_ channel.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  node_byte;
    logic [31:0] node_link;
    logic [31:0] entry_low;
    logic [63:0] entry_value;
    logic        run_end;
  } index_result_t;

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [63:0] in_key       = '0;
  logic [63:0] in_payload   = '0;
  logic        in_final_row = 1'b0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_node_byte;
  logic [31:0] out_node_link;
  logic [31:0] out_entry_low;
  logic [63:0] out_entry_value;
  logic        out_run_end;

  // Index state as the block should hold it.
  logic [31:0] last_prefix;
  logic [63:0] level1_nodes;
  logic [63:0] level2_nodes;
  logic [63:0] level3_nodes;
  logic [63:0] next_row;
  logic        table_open;

  index_result_t pending_results[$];

  int unsigned idle_pct = DEFAULT_IDLE;
  int unsigned hold_seq = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  int unsigned tables_closed = 0;
  int unsigned input_stall_cycles = 0;

  radix_prefix_index_builder #(
    .COUNT_WIDTH(COUNT_W)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_key         (in_key),
    .in_payload     (in_payload),
    .in_final_row   (in_final_row),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_node_byte  (out_node_byte),
    .out_node_link  (out_node_link),
    .out_entry_low  (out_entry_low),
    .out_entry_value(out_entry_value),
    .out_run_end    (out_run_end)
  );

  // 2 ns clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] bump_count(input logic [63:0] count);
    return (count >= COUNT_CAP) ? COUNT_CAP : count + 64'd1;
  endfunction

  function automatic logic [7:0] prefix_byte(input logic [31:0] prefix, input int unsigned lvl);
    return prefix[31 - 8 * lvl -: 8];
  endfunction

  task automatic push_result(input logic [2:0] kind, input logic [7:0] node_byte,
                             input logic [31:0] node_link, input logic [31:0] entry_low,
                             input logic [63:0] entry_value, input logic run_end);
    index_result_t res;
    res = '{kind: kind, node_byte: node_byte, node_link: node_link, entry_low: entry_low,
            entry_value: entry_value, run_end: run_end};
    pending_results = {pending_results, res};
  endtask

  // Closes the node of one level; level 3 nodes link to the given row.
  task automatic close_index_node(input int unsigned lvl, input logic [63:0] row,
                                  input logic run_end);
    logic [63:0] link;
    case (lvl)
      0: link = level1_nodes;
      1: link = level2_nodes;
      2: link = level3_nodes;
      default: link = row;
    endcase
    push_result(3'(KIND_NODE0 + lvl), prefix_byte(last_prefix, lvl), link[31:0], '0, '0,
                run_end);
    case (lvl)
      1: level1_nodes = bump_count(level1_nodes);
      2: level2_nodes = bump_count(level2_nodes);
      3: level3_nodes = bump_count(level3_nodes);
      default: ;
    endcase
  endtask

  task automatic clear_index_state();
    last_prefix  = '0;
    level1_nodes = '0;
    level2_nodes = '0;
    level3_nodes = '0;
    next_row     = '0;
    table_open   = 1'b0;
  endtask

  // Works out every result of one accepted request, in emission order.
  task automatic predict_request(input logic [63:0] key, input logic [63:0] value,
                                 input logic last_row);
    logic [31:0] prefix;
    logic [63:0] row;
    int          first_changed;
    prefix = key[63:32];
    // Seed nodes open a new table.
    if (!table_open) begin
      for (int unsigned lvl = 0; lvl < NUM_LEVELS; lvl++)
        push_result(3'(KIND_NODE0 + lvl), '0, '0, '0, '0, 1'b0);
      level1_nodes = 64'd1;
      level2_nodes = 64'd1;
      level3_nodes = 64'd1;
      next_row     = '0;
      last_prefix  = prefix;
      table_open   = 1'b1;
    end
    row = next_row;
    // The highest level whose byte differs closes itself and all lower levels.
    first_changed = NUM_LEVELS;
    for (int lvl = NUM_LEVELS - 1; lvl >= 0; lvl--)
      if (prefix_byte(prefix, lvl) != prefix_byte(last_prefix, lvl)) first_changed = lvl;
    if (first_changed < NUM_LEVELS) begin
      for (int unsigned lvl = first_changed; lvl < NUM_LEVELS; lvl++)
        close_index_node(lvl, (row == 0) ? 64'd0 : row - 64'd1, 1'b0);
      last_prefix = prefix;
    end
    push_result(KIND_ENTRY, '0, '0, key[31:0], value, !last_row);
    // The last row flushes all levels and ends the table.
    if (last_row) begin
      for (int unsigned lvl = 0; lvl < NUM_LEVELS; lvl++)
        close_index_node(lvl, row, lvl == NUM_LEVELS - 1);
      clear_index_state();
    end else begin
      next_row = bump_count(next_row);
    end
  endtask

  // Offers one request after a random gap and waits until it is taken.
  task automatic send_request(input logic [63:0] key, input logic [63:0] value,
                              input logic last_row);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid     <= 1'b0;
      in_key       <= {$urandom, $urandom};
      in_payload   <= {$urandom, $urandom};
      in_final_row <= 1'($urandom_range(0, 1));
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_key       <= key;
    in_payload   <= value;
    in_final_row <= last_row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(key, value, last_row);
    requests_sent++;
    if (last_row) tables_closed++;
  endtask

  // Next key of a sorted table: a low-bit step or a step at one prefix level.
  function automatic logic [63:0] next_sorted_key(input logic [63:0] cur);
    int unsigned pick;
    int unsigned shift;
    logic [63:0] upper;
    logic [63:0] noise;
    pick  = $urandom_range(0, 99);
    noise = {$urandom, $urandom};
    if (pick < 40) return cur + 64'($urandom_range(1, 1000));
    shift = (pick < 55) ? 32 : (pick < 70) ? 40 : (pick < 85) ? 48 : 56;
    upper = (cur >> shift) + 64'($urandom_range(1, 3));
    return (upper << shift) | (noise & ((64'd1 << shift) - 64'd1));
  endfunction

  // Random tables, mostly sorted, with a few keys out of order.
  task automatic run_random_tables(input int unsigned item_goal);
    int unsigned sent;
    int unsigned rows;
    logic [63:0] key;
    sent = 0;
    while (sent < item_goal) begin
      rows = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      if (rows > item_goal - sent) rows = item_goal - sent;
      key = {$urandom, $urandom};
      for (int unsigned r = 0; r < rows; r++) begin
        if ($urandom_range(0, 99) < 8) key = {$urandom, $urandom};
        else if (r != 0) key = next_sorted_key(key);
        send_request(key, {$urandom, $urandom}, r == rows - 1);
        sent++;
      end
    end
  endtask

  // Tables of one row: seeds, entry and flush together, at the key extremes.
  task automatic test_single_row_tables();
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_request(64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000, 1'b1);
    send_request(64'h8000_0000_0000_0001, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
  endtask

  // One table that changes each prefix level in turn, ending on a change.
  task automatic test_level_changes();
    send_request(64'h0102_0304_0000_0010, 64'h5555_5555_5555_5555, 1'b0);
    send_request(64'h0102_0304_0000_0020, 64'h0000_0000_0000_0001, 1'b0);
    send_request(64'h0102_0305_1234_5678, 64'h8000_0000_0000_0000, 1'b0);
    send_request(64'h0102_0405_0000_0000, 64'h0123_4567_89AB_CDEF, 1'b0);
    send_request(64'h0103_0000_FFFF_FFFF, 64'hFEDC_BA98_7654_3210, 1'b0);
    send_request(64'h0200_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_request(64'h0200_0001_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
  endtask

  // Falling keys close nodes just as rising ones do.
  task automatic test_unsorted_keys();
    send_request(64'hFF00_0000_0000_0000, 64'h1111_1111_1111_1111, 1'b0);
    send_request(64'h0000_0000_0000_0000, 64'h2222_2222_2222_2222, 1'b0);
    send_request(64'hFFFF_FFFF_0000_0000, 64'h3333_3333_3333_3333, 1'b0);
    send_request(64'h0000_00FF_FFFF_FFFF, 64'h4444_4444_4444_4444, 1'b1);
  endtask

  // A long stretch with neither side idling.
  task automatic test_no_idle_stretch();
    idle_pct = 0;
    run_random_tables(80);
    idle_pct = DEFAULT_IDLE;
  endtask

  // The receiver holds off while requests keep coming, so in_stall rises.
  task automatic test_output_backpressure();
    logic [63:0] key;
    hold_seq <= hold_seq + 1;
    key = {8'h40, 8'($urandom_range(0, 255)), 48'h0};
    for (int unsigned r = 0; r < 30; r++) begin
      key = key + 64'($urandom_range(1, 50));
      send_request(key, {$urandom, $urandom}, r == 29);
    end
  endtask

  // Receiver stalls: random, or held high for a long stretch on request.
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < idle_pct);
    end
  end

  // Each accepted result must match the oldest expectation.
  always @(posedge clk) begin
    index_result_t seen;
    index_result_t want;
    if (rst_n && in_valid && in_stall) input_stall_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      seen = '{kind: out_kind, node_byte: out_node_byte, node_link: out_node_link,
               entry_low: out_entry_low, entry_value: out_entry_value, run_end: out_run_end};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: result with nothing expected: kind %0d byte %h link %h",
                   seen.kind, seen.node_byte, seen.node_link);
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("ERROR: result %0d mismatch", results_seen);
            $display("  kind        exp %0d got %0d", want.kind, seen.kind);
            $display("  node_byte   exp %h got %h", want.node_byte, seen.node_byte);
            $display("  node_link   exp %h got %h", want.node_link, seen.node_link);
            $display("  entry_low   exp %h got %h", want.entry_low, seen.entry_low);
            $display("  entry_value exp %h got %h", want.entry_value, seen.entry_value);
            $display("  run_end     exp %b got %b", want.run_end, seen.run_end);
          end
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    clear_index_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_row_tables();
    test_level_changes();
    test_unsorted_keys();
    run_random_tables(210);
    test_no_idle_stretch();
    test_output_backpressure();

    // Let every expected result drain, then watch for strays.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests in %0d tables, %0d results checked, %0d mismatches.",
             requests_sent, tables_closed, results_seen, mismatches);
    $display("Input was held off for %0d cycles by output back-pressure.",
             input_stall_cycles);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
